FILE: src/pav_pkg.sv
// ---------------------------------------------------------------------------
// pav_pkg
// Shared types and constants for the averaged potentiometer setpoint block.
// ---------------------------------------------------------------------------
`default_nettype none

package pav_pkg;

    localparam int WINDOW       = 10;
    localparam int SAMPLE_W     = 10;
    localparam int ADC_FULL     = 1023;
    localparam int SPEED_SPAN   = 198;
    localparam int SPEED_OFFSET = 99;
    localparam int ANGLE_SPAN   = 180;
    localparam int ANGLE_OFFSET = 90;
    localparam int MOTOR_MUL    = 1999;
    localparam int MOTOR_DIV    = 100;
    localparam int SERVO_STEP   = 4500 / ANGLE_SPAN;
    localparam int SERVO_BASE   = 1500;

    // window sum and the divisor that folds the average in
    localparam int DIVISOR = WINDOW * ADC_FULL;
    localparam int SUM_W   = $clog2(DIVISOR + 1);

    // floor(sum*span/DIVISOR) = (sum*recip) >> SCALE_SHIFT, exact since sum*DIVISOR < 2^shift
    localparam int    SCALE_SHIFT = 2 * SUM_W;
    localparam longint SPEED_RECIP =
        ((longint'(1) << SCALE_SHIFT) * SPEED_SPAN + DIVISOR - 1) / DIVISOR;
    localparam longint ANGLE_RECIP =
        ((longint'(1) << SCALE_SHIFT) * ANGLE_SPAN + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W = $clog2(SPEED_RECIP + 1);
    localparam int PROD_W  = SUM_W + RECIP_W;

    localparam int SMAG_W  = 7;
    localparam int MOTOR_W = 11;
    localparam int SERVO_W = 13;

    typedef struct packed {
        logic [SAMPLE_W-1:0] speed_sample;
        logic [SAMPLE_W-1:0] angle_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0]   speed_setting;
        logic [SMAG_W-1:0]   speed_magnitude;
        logic signed [7:0]   angle_setting;
        logic [7:0]          angle_magnitude;
        logic                bridge_in1;
        logic                bridge_in2;
        logic [MOTOR_W-1:0]  motor_pulse;
        logic [SERVO_W-1:0]  servo_pulse;
    } t_out_item;

    typedef struct packed {
        logic [SUM_W-1:0] speed_sum;
        logic [SUM_W-1:0] angle_sum;
    } t_sums;

    typedef logic [(1<<SMAG_W)-1:0][MOTOR_W-1:0] t_motor_lut;

    function automatic t_motor_lut build_motor_lut();
        t_motor_lut lut;
        for (int i = 0; i < (1 << SMAG_W); i++) begin
            lut[i] = MOTOR_W'((i * MOTOR_MUL) / MOTOR_DIV);
        end
        return lut;
    endfunction

    localparam t_motor_lut MOTOR_LUT = build_motor_lut();

endpackage

`default_nettype wire

FILE: src/pav_cell.sv
// ---------------------------------------------------------------------------
// pav_cell
// One window cell: holds a sample pair and passes it on when the window shifts.
// ---------------------------------------------------------------------------
`default_nettype none

module pav_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_shift,
    input  pav_pkg::t_in_item   i_pair,
    output pav_pkg::t_in_item   o_pair
);
    import pav_pkg::*;

    t_in_item r_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair <= '0;
        end else if (i_shift) begin
            r_pair <= i_pair;
        end
    end

    assign o_pair = r_pair;

endmodule

`default_nettype wire

FILE: src/pav_window.sv
// ---------------------------------------------------------------------------
// pav_window
// Chain of sample cells with running window sums for both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module pav_window (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  pav_pkg::t_in_item   i_in_item,
    output logic                o_valid,
    input  wire                 i_ready,
    output pav_pkg::t_sums      o_sums
);
    import pav_pkg::*;

    t_in_item chain [WINDOW+1];
    logic     accept;
    logic     r_valid;
    t_sums    r_sums;
    t_sums    n_sums;

    assign o_in_stall = r_valid && !i_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign chain[0]   = i_in_item;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        pav_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept),
            .i_pair  (chain[g]),
            .o_pair  (chain[g+1])
        );
    end

    // the last cell holds the item leaving the window
    always_comb begin
        n_sums.speed_sum = r_sums.speed_sum - SUM_W'(chain[WINDOW].speed_sample)
                         + SUM_W'(i_in_item.speed_sample);
        n_sums.angle_sum = r_sums.angle_sum - SUM_W'(chain[WINDOW].angle_sample)
                         + SUM_W'(i_in_item.angle_sample);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sums  <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_sums  <= n_sums;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_sums  = r_sums;

endmodule

`default_nettype wire

FILE: src/pav_setpoint.sv
// ---------------------------------------------------------------------------
// pav_setpoint
// Scales the window sums to setpoints and derives bridge and pulse values.
// ---------------------------------------------------------------------------
`default_nettype none

module pav_setpoint (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  pav_pkg::t_sums      i_sums,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output pav_pkg::t_out_item  o_out_item
);
    import pav_pkg::*;

    logic [PROD_W-1:0] speed_prod;
    logic [PROD_W-1:0] angle_prod;
    logic              r_q_valid;
    logic [7:0]        r_speed_q;
    logic [7:0]        r_angle_q;
    logic              out_ready;
    logic              q_ready;
    logic [8:0]        speed_wide;
    logic [SMAG_W-1:0] smag;
    t_out_item         n_item;
    t_out_item         r_item;
    logic              r_out_valid;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign q_ready   = !r_q_valid || out_ready;
    assign o_ready   = q_ready;

    // reciprocal multiply replaces the divide by the window divisor (WINDOW * ADC_FULL)
    assign speed_prod = PROD_W'(i_sums.speed_sum) * PROD_W'(SPEED_RECIP);
    assign angle_prod = PROD_W'(i_sums.angle_sum) * PROD_W'(ANGLE_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (q_ready) begin
            r_q_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_ready && i_valid) begin
            r_speed_q <= speed_prod[SCALE_SHIFT+7:SCALE_SHIFT];
            r_angle_q <= angle_prod[SCALE_SHIFT+7:SCALE_SHIFT];
        end
    end

    always_comb begin
        speed_wide = {1'b0, r_speed_q} - 9'(SPEED_OFFSET);
        if (r_speed_q >= 8'(SPEED_OFFSET)) begin
            smag = SMAG_W'(r_speed_q - 8'(SPEED_OFFSET));
        end else begin
            smag = SMAG_W'(8'(SPEED_OFFSET) - r_speed_q);
        end
        n_item.speed_setting   = signed'(speed_wide[7:0]);
        n_item.speed_magnitude = smag;
        n_item.angle_setting   = signed'(r_angle_q - 8'(ANGLE_OFFSET));
        n_item.angle_magnitude = r_angle_q;
        n_item.bridge_in1      = r_speed_q > 8'(SPEED_OFFSET);
        n_item.bridge_in2      = r_speed_q < 8'(SPEED_OFFSET);
        n_item.motor_pulse     = MOTOR_LUT[smag];
        n_item.servo_pulse     = SERVO_W'(r_angle_q) * SERVO_W'(SERVO_STEP)
                               + SERVO_W'(SERVO_BASE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_q_valid) begin
            r_item <= n_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_item;

endmodule

`default_nettype wire

FILE: src/pot_average_motor_servo_setpoint.sv
// ---------------------------------------------------------------------------
// pot_average_motor_servo_setpoint
// Moving average of two potentiometer channels turned into motor and servo
// setpoints.
// ---------------------------------------------------------------------------
// usage:
//   input channel: i_in_valid / o_in_stall carry one item, a pair of 10-bit
//   samples (speed, angle). each accepted item shifts the pair into a chain of
//   WINDOW cells and updates the running sum of each channel.
//   output channel: o_out_valid / i_out_stall carry one result item per input
//   item: signed speed and angle, their magnitudes, h-bridge bits, motor and
//   servo compare values.
//   the result passes through the window sum register, the quotient register
//   and the output register. the block takes one item per cycle while o_in_stall
//   is low, set by the sum update in the window; the three stages each hold one item.
//   reset: all cells and sums clear to zero, so the first WINDOW-1 results
//   average in zero samples; no items are in flight.
//   stall: a stalled result holds in the output register; earlier stages keep
//   filling and o_in_stall rises only once every stage holds an item.
// ---------------------------------------------------------------------------
`default_nettype none

module pot_average_motor_servo_setpoint (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  pav_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output pav_pkg::t_out_item  o_out_item
);
    import pav_pkg::*;

    logic  sums_valid;
    logic  sums_ready;
    t_sums sums;

    pav_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_valid    (sums_valid),
        .i_ready    (sums_ready),
        .o_sums     (sums)
    );

    pav_setpoint u_setpoint (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (sums_valid),
        .o_ready     (sums_ready),
        .i_sums      (sums),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks pot_average_motor_servo_setpoint. Sample pairs go in over the input
// channel and an in-bench copy of the averaging window predicts every
// setpoint result. Each result is compared field by field, in order. Sender
// gaps and receiver stalls are mixed in, along with one long output hold-off
// that backs up the input.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pav_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTS   = 40;
    localparam int SERVO_FULL   = 4500;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    pot_average_motor_servo_setpoint dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the averaging window
    logic [SAMPLE_W-1:0] window_speed [WINDOW] = '{default: '0};
    logic [SAMPLE_W-1:0] window_angle [WINDOW] = '{default: '0};
    int fill_slot   = 0;
    int speed_total = 0;
    int angle_total = 0;

    t_out_item setpoint_queue [$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;

    int mismatches     = 0;
    int pairs_in       = 0;
    int results_out    = 0;
    int stopped_seen   = 0;
    int full_seen      = 0;
    int in_stall_count = 0;
    int quiet_cycles   = 0;

    function automatic t_out_item predict_setpoints(t_in_item pair);
        t_out_item r;
        int speed, smag, amag;
        speed_total = speed_total - window_speed[fill_slot] + pair.speed_sample;
        angle_total = angle_total - window_angle[fill_slot] + pair.angle_sample;
        window_speed[fill_slot] = pair.speed_sample;
        window_angle[fill_slot] = pair.angle_sample;
        fill_slot = (fill_slot + 1) % WINDOW;

        speed = speed_total * SPEED_SPAN / (WINDOW * ADC_FULL) - SPEED_OFFSET;
        smag  = (speed < 0) ? -speed : speed;
        amag  = angle_total * ANGLE_SPAN / (WINDOW * ADC_FULL);

        r.speed_setting   = 8'(speed);
        r.speed_magnitude = 7'(smag);
        r.angle_setting   = 8'(amag - ANGLE_OFFSET);
        r.angle_magnitude = 8'(amag);
        r.bridge_in1      = (speed > 0);
        r.bridge_in2      = (speed < 0);
        r.motor_pulse     = 11'(smag * MOTOR_MUL / MOTOR_DIV);
        r.servo_pulse     = 13'(amag * SERVO_FULL / ANGLE_SPAN + SERVO_BASE);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("mismatch at result %0d: %s", results_out, msg);
        end
    endtask

    task automatic check_field(string name, logic signed [31:0] got,
                               logic signed [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // input predictions and output checks, sampled at the edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                setpoint_queue.push_back(predict_setpoints(i_in_item));
                pairs_in++;
            end
            if (i_in_valid && o_in_stall) begin
                in_stall_count++;
            end
            if (o_out_valid && !i_out_stall) begin
                results_out++;
                if (setpoint_queue.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = setpoint_queue.pop_front();
                    if (want.speed_magnitude == 0) stopped_seen++;
                    if (want.speed_magnitude == SPEED_OFFSET) full_seen++;
                    check_field("speed_setting", o_out_item.speed_setting,
                                want.speed_setting);
                    check_field("speed_magnitude", o_out_item.speed_magnitude,
                                want.speed_magnitude);
                    check_field("angle_setting", o_out_item.angle_setting,
                                want.angle_setting);
                    check_field("angle_magnitude", o_out_item.angle_magnitude,
                                want.angle_magnitude);
                    check_field("bridge_in1", o_out_item.bridge_in1, want.bridge_in1);
                    check_field("bridge_in2", o_out_item.bridge_in2, want.bridge_in2);
                    check_field("motor_pulse", o_out_item.motor_pulse,
                                want.motor_pulse);
                    check_field("servo_pulse", o_out_item.servo_pulse,
                                want.servo_pulse);
                end
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_pair(logic [SAMPLE_W-1:0] spd, logic [SAMPLE_W-1:0] ang);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{speed_sample: spd, angle_sample: ang};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // rails, levels around the stop band near mid scale, or anything
    function automatic logic [SAMPLE_W-1:0] pick_level();
        case ($urandom_range(3))
            0:       return '0;
            1:       return 10'(ADC_FULL);
            2:       return 10'($urandom_range(505, 525));
            default: return 10'($urandom_range(ADC_FULL));
        endcase
    endfunction

    // zeros still in the window pull the first results down
    task automatic test_warmup();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (WINDOW) send_pair(10'(ADC_FULL), 10'(ADC_FULL));
    endtask

    // mid scale settles into the stop band: both bridge bits low
    task automatic test_speed_stop();
        repeat (WINDOW) send_pair(10'd512, 10'd512);
        send_pair(10'd515, 10'd0);
    endtask

    task automatic test_bit_patterns();
        send_pair(10'h000, 10'h3FF);
        send_pair(10'h2AA, 10'h155);
        send_pair(10'h155, 10'h2AA);
        send_pair(10'h3FF, 10'h000);
    endtask

    task automatic test_random_traffic(int n_items, int send_idle, int recv_stall);
        int sent, run;
        logic [SAMPLE_W-1:0] s_lvl, a_lvl;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(2))
                0: begin
                    send_pair(10'($urandom_range(ADC_FULL)), 10'($urandom_range(ADC_FULL)));
                    sent++;
                end
                1: begin
                    // steady level long enough to flush the whole window
                    run   = $urandom_range(WINDOW, WINDOW + 4);
                    s_lvl = pick_level();
                    a_lvl = pick_level();
                    repeat (run) send_pair(s_lvl, a_lvl);
                    sent += run;
                end
                default: begin
                    run = $urandom_range(3, 8);
                    repeat (run) send_pair(pick_level(), 10'($urandom_range(ADC_FULL)));
                    sent += run;
                end
            endcase
        end
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (48) send_pair(10'($urandom_range(ADC_FULL)), 10'($urandom_range(ADC_FULL)));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_warmup();
        test_speed_stop();
        test_bit_patterns();
        test_random_traffic(320, 0, 0);
        test_random_traffic(320, 59, 0);
        test_random_traffic(320, 0, 59);
        test_random_traffic(320, 13, 13);
        test_backpressure();

        i_in_valid <= 1'b0;
        stall_pct = 0;
        while (setpoint_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (setpoint_queue.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", setpoint_queue.size()));
        end

        $display("covered %0d sample pairs, %0d results checked (%0d stopped, %0d full speed)",
                 pairs_in, results_out, stopped_seen, full_seen);
        $display("input stalled in %0d cycles, %0d mismatches", in_stall_count, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
